[sv/lfu_pkg.sv]
// Shared types and constants for the LFU key-value store.
// Holds the request/response word layouts and fixed field widths; no dependencies.
package lfu_pkg;

   localparam int KEY_W  = 32;
   localparam int DATA_W = 32;
   localparam int CAP_W  = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic ACT_GET = 1'b0;
   localparam logic ACT_PUT = 1'b1;

   typedef struct packed {
      logic              action;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] read_value;
   } rsp_type;

   typedef struct packed {
      logic match_found;
      logic vic_found;
      logic free_found;
   } scan_flags_type;

endpackage

[sv/lfu_entry_ram.sv]
// Entry storage for the LFU store: one write port, one registered read port.
// Generic width and depth; no package dependencies.
module lfu_entry_ram #(
   parameter int WIDTH = 84,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/lfu_scan_unit.sv]
// Shared compare unit: checks the entries one per cycle while en is high, finding the key match,
// the eviction victim and the first free slot. Uses lfu_pkg.
module lfu_scan_unit #(
   parameter int IDX_W      = 4,
   parameter int COUNT_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  logic                         en,
   input  logic [IDX_W-1:0]             idx,
   input  logic                         entry_valid,
   input  logic [lfu_pkg::KEY_W-1:0]    key,
   input  logic [lfu_pkg::KEY_W-1:0]    rec_key,
   input  logic [lfu_pkg::DATA_W-1:0]   rec_data,
   input  logic [COUNT_BITS-1:0]        rec_count,
   input  logic [IDX_W-1:0]             rec_rank,
   output lfu_pkg::scan_flags_type      flags,
   output logic [IDX_W-1:0]             match_idx,
   output logic [IDX_W-1:0]             match_rank,
   output logic [lfu_pkg::DATA_W-1:0]   match_data,
   output logic [IDX_W-1:0]             vic_idx,
   output logic [IDX_W-1:0]             vic_rank,
   output logic [IDX_W-1:0]             free_idx
);

   lfu_pkg::scan_flags_type    flags_ff;
   logic [IDX_W-1:0]           match_idx_ff;
   logic [IDX_W-1:0]           match_rank_ff;
   logic [lfu_pkg::DATA_W-1:0] match_data_ff;
   logic [IDX_W-1:0]           vic_idx_ff;
   logic [IDX_W-1:0]           vic_rank_ff;
   logic [COUNT_BITS-1:0]      vic_count_ff;
   logic [IDX_W-1:0]           free_idx_ff;

   logic hit_now;
   logic vic_now;
   logic free_now;

   always_comb begin
      hit_now  = en && entry_valid && (rec_key == key) && !flags_ff.match_found;
      vic_now  = en && entry_valid &&
                 (!flags_ff.vic_found || (rec_count < vic_count_ff) ||
                  ((rec_count == vic_count_ff) && (rec_rank > vic_rank_ff)));
      free_now = en && !entry_valid && !flags_ff.free_found;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         flags_ff <= '0;
      end else begin
         if (hit_now)  flags_ff.match_found <= 1'b1;
         if (vic_now)  flags_ff.vic_found   <= 1'b1;
         if (free_now) flags_ff.free_found  <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (hit_now) begin
         match_idx_ff  <= idx;
         match_rank_ff <= rec_rank;
         match_data_ff <= rec_data;
      end
      if (vic_now) begin
         vic_idx_ff   <= idx;
         vic_rank_ff  <= rec_rank;
         vic_count_ff <= rec_count;
      end
      if (free_now) begin
         free_idx_ff <= idx;
      end
   end

   assign flags      = flags_ff;
   assign match_idx  = match_idx_ff;
   assign match_rank = match_rank_ff;
   assign match_data = match_data_ff;
   assign vic_idx    = vic_idx_ff;
   assign vic_rank   = vic_rank_ff;
   assign free_idx   = free_idx_ff;

endmodule

[sv/lfu_cache_lookup_insert.sv]
// LFU key-value store, top level: sequencer, valid bits and response register.
// One word in flight. A scan pass reads every entry once; a put that updates or inserts and a
// get hit then read every entry once more in the rank update pass, while a get miss or a put
// at zero capacity skips it (that put is dropped); a held response stalls the result step.
// Reset (synchronous): clears valid bits, fill count, sequencer; capacity becomes 16.
module lfu_cache_lookup_insert #(
   parameter int ENTRIES    = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  lfu_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output lfu_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  logic [lfu_pkg::CAP_W-1:0]    csr_wdata
);

   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int CMP_W   = (CNT_W > lfu_pkg::CAP_W) ? CNT_W : lfu_pkg::CAP_W;
   localparam int REC_W   = lfu_pkg::KEY_W + lfu_pkg::DATA_W + COUNT_BITS + IDX_W;
   localparam int RANK_LO = 0;
   localparam int CNT_LO  = IDX_W;
   localparam int DATA_LO = IDX_W + COUNT_BITS;
   localparam int KEY_LO  = IDX_W + COUNT_BITS + lfu_pkg::DATA_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_RESULT
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        addr_ff, addr_in;
   logic                    pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]        pipe_idx_ff, pipe_idx_in;
   lfu_pkg::req_type        req_ff, req_in;
   logic                    insert_ff, insert_in;
   logic                    evict_ff, evict_in;
   logic                    get_hit_ff, get_hit_in;
   logic [IDX_W-1:0]        ins_idx_ff, ins_idx_in;
   lfu_pkg::rsp_type        res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   lfu_pkg::rsp_type        rsp_data_ff, rsp_data_in;
   logic [ENTRIES-1:0]      valid_ff, valid_in;
   logic [CNT_W-1:0]        stored_ff, stored_in;
   logic [lfu_pkg::CAP_W-1:0] capacity_ff, capacity_in;

   logic                    rd_en;
   logic [REC_W-1:0]        rd_data;
   logic                    wr_en;
   logic [REC_W-1:0]        wr_data;
   logic                    scan_clear;
   logic                    scan_en;
   logic                    pipe_entry_valid;

   logic [lfu_pkg::KEY_W-1:0]  rec_key;
   logic [lfu_pkg::DATA_W-1:0] rec_data;
   logic [COUNT_BITS-1:0]      rec_count;
   logic [IDX_W-1:0]           rec_rank;

   lfu_pkg::scan_flags_type    flags;
   logic [IDX_W-1:0]           match_idx;
   logic [IDX_W-1:0]           match_rank;
   logic [lfu_pkg::DATA_W-1:0] match_data;
   logic [IDX_W-1:0]           vic_idx;
   logic [IDX_W-1:0]           vic_rank;
   logic [IDX_W-1:0]           free_idx;

   logic [CMP_W-1:0]        cap_ext;
   logic [CMP_W-1:0]        eff_cap;
   logic                    cap_zero;
   logic                    need_evict;
   logic                    pass_done;
   logic                    is_get;
   logic                    dec_rank;

   assign rec_rank  = rd_data[RANK_LO +: IDX_W];
   assign rec_count = rd_data[CNT_LO +: COUNT_BITS];
   assign rec_data  = rd_data[DATA_LO +: lfu_pkg::DATA_W];
   assign rec_key   = rd_data[KEY_LO +: lfu_pkg::KEY_W];

   assign pipe_entry_valid = valid_ff[pipe_idx_ff];
   assign scan_en          = (state_ff == ST_SCAN) && pipe_vld_ff;
   assign scan_clear       = req_valid && req_ready;
   assign rd_en            = ((state_ff == ST_SCAN) || (state_ff == ST_UPDATE)) &&
                             (addr_ff != CNT_W'(ENTRIES));
   assign wr_en            = (state_ff == ST_UPDATE) && pipe_vld_ff;
   assign pass_done        = (addr_ff == CNT_W'(ENTRIES)) && !pipe_vld_ff;
   assign is_get           = (req_ff.action == lfu_pkg::ACT_GET);

   lfu_entry_ram #(
      .WIDTH (REC_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pipe_idx_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   lfu_scan_unit #(
      .IDX_W      (IDX_W),
      .COUNT_BITS (COUNT_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .clear       (scan_clear),
      .en          (scan_en),
      .idx         (pipe_idx_ff),
      .entry_valid (pipe_entry_valid),
      .key         (req_ff.key),
      .rec_key     (rec_key),
      .rec_data    (rec_data),
      .rec_count   (rec_count),
      .rec_rank    (rec_rank),
      .flags       (flags),
      .match_idx   (match_idx),
      .match_rank  (match_rank),
      .match_data  (match_data),
      .vic_idx     (vic_idx),
      .vic_rank    (vic_rank),
      .free_idx    (free_idx)
   );

   // effective capacity and fill check
   always_comb begin
      cap_ext    = CMP_W'(capacity_ff);
      eff_cap    = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
      cap_zero   = (capacity_ff == '0);
      need_evict = (CMP_W'(stored_ff) >= eff_cap);
   end

   // rank update pass: new record for the entry now leaving the RAM
   always_comb begin
      wr_data  = rd_data;
      dec_rank = evict_ff && (rec_rank > vic_rank);
      if (!insert_ff) begin
         if (pipe_idx_ff == match_idx) begin
            wr_data[RANK_LO +: IDX_W] = '0;
            wr_data[CNT_LO +: COUNT_BITS] = (rec_count == {COUNT_BITS{1'b1}}) ?
                                            rec_count : rec_count + COUNT_BITS'(1);
            if (!is_get) begin
               wr_data[DATA_LO +: lfu_pkg::DATA_W] = req_ff.value;
            end
         end else if (pipe_entry_valid && (rec_rank < match_rank)) begin
            wr_data[RANK_LO +: IDX_W] = rec_rank + IDX_W'(1);
         end
      end else begin
         if (pipe_idx_ff == ins_idx_ff) begin
            wr_data = {req_ff.key, req_ff.value, COUNT_BITS'(1), IDX_W'(0)};
         end else if (pipe_entry_valid && !(evict_ff && (pipe_idx_ff == vic_idx))) begin
            wr_data[RANK_LO +: IDX_W] = rec_rank + IDX_W'(1) - IDX_W'(dec_rank);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      pipe_vld_in  = rd_en;
      pipe_idx_in  = addr_ff[IDX_W-1:0];
      req_in       = req_ff;
      insert_in    = insert_ff;
      evict_in     = evict_ff;
      get_hit_in   = get_hit_ff;
      ins_idx_in   = ins_idx_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      valid_in     = valid_ff;
      stored_in    = stored_ff;
      capacity_in  = csr_we ? csr_wdata : capacity_ff;

      if (rd_en) begin
         addr_in = addr_ff + CNT_W'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               addr_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (pass_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            addr_in    = '0;
            res_in     = '0;
            insert_in  = 1'b0;
            evict_in   = 1'b0;
            get_hit_in = 1'b0;
            if (cap_zero) begin
               state_in = is_get ? ST_RESULT : ST_IDLE;
            end else if (flags.match_found) begin
               get_hit_in = is_get;
               res_in.hit = 1'b1;
               res_in.read_value = match_data;
               state_in   = ST_UPDATE;
            end else if (is_get) begin
               state_in = ST_RESULT;
            end else begin
               insert_in = 1'b1;
               evict_in  = need_evict && flags.vic_found;
               if (need_evict && flags.vic_found) begin
                  ins_idx_in = (flags.free_found && (free_idx < vic_idx)) ?
                               free_idx : vic_idx;
               end else begin
                  ins_idx_in = free_idx;
               end
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (pass_done) begin
               if (insert_ff) begin
                  if (evict_ff) begin
                     valid_in[vic_idx] = 1'b0;
                  end
                  valid_in[ins_idx_ff] = 1'b1;
                  stored_in = evict_ff ? stored_ff : stored_ff + CNT_W'(1);
               end
               state_in = get_hit_ff ? ST_RESULT : ST_IDLE;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         addr_ff      <= '0;
         pipe_vld_ff  <= 1'b0;
         insert_ff    <= 1'b0;
         evict_ff     <= 1'b0;
         get_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         stored_ff    <= '0;
         capacity_ff  <= lfu_pkg::CAP_RESET;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         pipe_vld_ff  <= pipe_vld_in;
         insert_ff    <= insert_in;
         evict_ff     <= evict_in;
         get_hit_ff   <= get_hit_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         stored_ff    <= stored_in;
         capacity_ff  <= capacity_in;
      end
      pipe_idx_ff <= pipe_idx_in;
      req_ff      <= req_in;
      ins_idx_ff  <= ins_idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_fill_count : assert property (@(posedge clock) disable iff (reset)
      CNT_W'($countones(valid_ff)) == stored_ff)
      else $error("fill count disagrees with valid bits");

   a_accept_scan : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SCAN))
      else $error("accepted word did not start a scan");

   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESULT))
      else $error("response raised outside result state");

   a_valid_hold : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && ($past(state_ff) == ST_SCAN)) |-> $stable(valid_ff))
      else $error("valid bits changed during scan");

endmodule

[sim/tb_lfu_cache_lookup_insert.sv]
`timescale 1ns / 1ps
// Testbench for the LFU key-value store: directed lookups, inserts and evictions, then random
// traffic at several capacities with random idling and one long result hold-off.
// Depends on lfu_pkg and lfu_cache_lookup_insert; counters are built narrow so they saturate.
module tb_lfu_cache_lookup_insert;

   localparam int SLOTS         = 16;
   localparam int USE_BITS      = 4;
   localparam int SETTLE_CYCLES = 60;
   localparam int CYCLE_LIMIT   = 1_000_000;

   logic                          clock;
   logic                          reset     = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   lfu_pkg::req_type              req_data  = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   lfu_pkg::rsp_type              rsp_data;
   logic                          csr_we    = 1'b0;
   logic [lfu_pkg::CAP_W-1:0]     csr_wdata = '0;

   logic [lfu_pkg::CAP_W-1:0]     cap_reg = lfu_pkg::CAP_RESET;
   logic                          slot_used [SLOTS];
   logic [lfu_pkg::KEY_W-1:0]     slot_key  [SLOTS];
   logic [lfu_pkg::DATA_W-1:0]    slot_val  [SLOTS];
   logic [USE_BITS-1:0]           slot_uses [SLOTS];
   int                            slot_age  [SLOTS];
   int                            fill_level = 0;
   lfu_pkg::rsp_type              reads_due [$];

   bit                   req_gaps_on   = 1'b1;
   bit                   rsp_stalls_on = 1'b1;
   int                   hold_off      = 0;
   int                   error_count   = 0;
   int                   cycle_count   = 0;

   lfu_cache_lookup_insert #(
      .ENTRIES    (SLOTS),
      .COUNT_BITS (USE_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_lfu_cache_lookup_insert: errors");
         $finish;
      end
   end

   function automatic int cap_in_use();
      return (cap_reg > SLOTS) ? SLOTS : int'(cap_reg);
   endfunction

   function automatic int find_slot(logic [lfu_pkg::KEY_W-1:0] k);
      for (int i = 0; i < SLOTS; i++)
         if (slot_used[i] && slot_key[i] == k)
            return i;
      return -1;
   endfunction

   function automatic void touch_slot(int s);
      int r;
      r = slot_age[s];
      for (int i = 0; i < SLOTS; i++)
         if (slot_used[i] && i != s && slot_age[i] < r)
            slot_age[i]++;
      slot_age[s] = 0;
      if (slot_uses[s] != '1)
         slot_uses[s]++;
   endfunction

   function automatic void evict_victim();
      int v;
      int r;
      v = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (!slot_used[i])
            continue;
         if (v < 0 || slot_uses[i] < slot_uses[v] ||
             (slot_uses[i] == slot_uses[v] && slot_age[i] > slot_age[v]))
            v = i;
      end
      if (v < 0)
         return;
      r = slot_age[v];
      slot_used[v] = 1'b0;
      for (int i = 0; i < SLOTS; i++)
         if (slot_used[i] && slot_age[i] > r)
            slot_age[i]--;
      if (fill_level > 0)
         fill_level--;
   endfunction

   function automatic void insert_entry(logic [lfu_pkg::KEY_W-1:0] k,
                                        logic [lfu_pkg::DATA_W-1:0] v);
      int f;
      f = -1;
      if (fill_level >= cap_in_use())
         evict_victim();
      for (int i = 0; i < SLOTS; i++)
         if (!slot_used[i] && f < 0)
            f = i;
      if (f < 0)
         return;
      for (int i = 0; i < SLOTS; i++)
         if (slot_used[i])
            slot_age[i]++;
      slot_used[f] = 1'b1;
      slot_key[f]  = k;
      slot_val[f]  = v;
      slot_uses[f] = 1;
      slot_age[f]  = 0;
      fill_level++;
   endfunction

   function automatic void apply_to_store(lfu_pkg::req_type w);
      int               s;
      lfu_pkg::rsp_type r;
      if (w.action == lfu_pkg::ACT_GET) begin
         r = '0;
         if (cap_in_use() != 0) begin
            s = find_slot(w.key);
            if (s >= 0) begin
               touch_slot(s);
               r.hit        = 1'b1;
               r.read_value = slot_val[s];
            end
         end
         reads_due.insert(reads_due.size(), r);
      end else if (cap_in_use() != 0) begin
         s = find_slot(w.key);
         if (s >= 0) begin
            slot_val[s] = w.value;
            touch_slot(s);
         end else begin
            insert_entry(w.key, w.value);
         end
      end
   endfunction

   function automatic int gap_draw(bit on);
      return on ? int'($urandom_range(0, 15)) : 0;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
      error_count++;
   endtask

   task automatic send_word(logic act, logic [lfu_pkg::KEY_W-1:0] k,
                            logic [lfu_pkg::DATA_W-1:0] v);
      lfu_pkg::req_type w;
      int               gap;
      w.action = act;
      w.key    = k;
      w.value  = v;
      gap = gap_draw(req_gaps_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      apply_to_store(w);
   endtask

   task automatic wait_store_idle();
      req_valid <= 1'b0;
      while (reads_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(logic [lfu_pkg::CAP_W-1:0] v);
      csr_wdata <= v;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      cap_reg = v;
   endtask

   // receiver: random stall per word, or a long hold when asked
   initial begin
      int n;
      while (reset) @(posedge clock);
      forever begin
         n = gap_draw(rsp_stalls_on);
         if (hold_off > 0) begin
            n = hold_off;
            hold_off = 0;
         end
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      lfu_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (reads_due.size() == 0) begin
            report_mismatch("unexpected word", rsp_data.read_value, '0);
         end else begin
            want = reads_due.pop_front();
            if (rsp_data.hit !== want.hit)
               report_mismatch("hit", {31'b0, rsp_data.hit}, {31'b0, want.hit});
            if (rsp_data.read_value !== want.read_value)
               report_mismatch("read_value", rsp_data.read_value, want.read_value);
         end
      end
   end

   task automatic test_empty_store();
      send_word(lfu_pkg::ACT_GET, 32'h0000_0000, 32'h0);
      send_word(lfu_pkg::ACT_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      wait_store_idle();
   endtask

   task automatic test_extreme_fields();
      send_word(lfu_pkg::ACT_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_word(lfu_pkg::ACT_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_word(lfu_pkg::ACT_GET, 32'hFFFF_FFFF, 32'h1234_5678);
      send_word(lfu_pkg::ACT_GET, 32'h0000_0000, 32'h0);
      send_word(lfu_pkg::ACT_PUT, 32'h0000_0000, 32'h5A5A_A5A5);
      send_word(lfu_pkg::ACT_GET, 32'h0000_0000, 32'h0);
      wait_store_idle();
   endtask

   // lowest count goes first; equal counts drop the least recent
   task automatic test_victim_choice();
      set_capacity(5'd2);
      send_word(lfu_pkg::ACT_PUT, 32'h0000_00A1, 32'hAAAA_0001);
      send_word(lfu_pkg::ACT_PUT, 32'h0000_00B2, 32'hBBBB_0002);
      send_word(lfu_pkg::ACT_GET, 32'h0000_00A1, 32'h0);
      send_word(lfu_pkg::ACT_PUT, 32'h0000_00C3, 32'hCCCC_0003);
      send_word(lfu_pkg::ACT_GET, 32'h0000_00B2, 32'h0);
      send_word(lfu_pkg::ACT_PUT, 32'h0000_00D4, 32'hDDDD_0004);
      send_word(lfu_pkg::ACT_GET, 32'h0000_00C3, 32'h0);
      send_word(lfu_pkg::ACT_GET, 32'h0000_00A1, 32'h0);
      send_word(lfu_pkg::ACT_GET, 32'h0000_00D4, 32'h0);
      send_word(lfu_pkg::ACT_PUT, 32'h0000_00E5, 32'hEEEE_0005);
      send_word(lfu_pkg::ACT_GET, 32'h0000_00A1, 32'h0);
      wait_store_idle();
   endtask

   task automatic test_zero_capacity();
      set_capacity(5'd0);
      send_word(lfu_pkg::ACT_PUT, 32'h0000_00F6, 32'hFFFF_0006);
      send_word(lfu_pkg::ACT_GET, 32'h0000_00F6, 32'h0);
      send_word(lfu_pkg::ACT_GET, 32'h0000_00D4, 32'h0);
      wait_store_idle();
   endtask

   task automatic test_capacity_above_slots();
      set_capacity(5'd31);
      send_word(lfu_pkg::ACT_GET, 32'h0000_00D4, 32'h0);
      send_word(lfu_pkg::ACT_GET, 32'h0000_00F6, 32'h0);
      wait_store_idle();
   endtask

   task automatic run_random_phase(logic [lfu_pkg::CAP_W-1:0] cap, int words, bit req_gaps,
                                   bit rsp_stalls, int hold);
      logic [lfu_pkg::KEY_W-1:0] pool [24];
      logic [lfu_pkg::KEY_W-1:0] k;
      logic                      act;
      int                        span;
      set_capacity(cap);
      for (int i = 0; i < 24; i++) begin
         if (i % 3 == 2)
            pool[i] = pool[i-1] ^ (32'h1 << $urandom_range(0, 31));
         else
            pool[i] = $urandom;
      end
      span = ((cap > SLOTS) ? SLOTS : int'(cap)) + 4;
      if (span > 23)
         span = 23;
      req_gaps_on   = req_gaps;
      rsp_stalls_on = rsp_stalls;
      hold_off      = hold;
      repeat (words) begin
         if ($urandom_range(0, 19) == 0)
            k = $urandom;
         else
            k = pool[$urandom_range(0, span)];
         act = ($urandom_range(0, 9) < 4) ? lfu_pkg::ACT_PUT : lfu_pkg::ACT_GET;
         send_word(act, k, $urandom);
      end
      wait_store_idle();
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      run_random_phase(5'd16, 300, 1'b1, 1'b1, 0);
      run_random_phase(5'd3,  200, 1'b1, 1'b1, 0);
      run_random_phase(5'd1,  100, 1'b1, 1'b0, 0);
      run_random_phase(5'd0,   50, 1'b0, 1'b1, 0);
      run_random_phase(5'd20, 200, 1'b0, 1'b0, 0);
      run_random_phase(5'($urandom_range(1, 16)), 300, 1'b1, 1'b1, 0);
   endtask

   task automatic test_backpressure();
      run_random_phase(5'd8, 200, 1'b0, 1'b1, 400);
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++)
         slot_used[i] = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_store();
      test_extreme_fields();
      test_victim_choice();
      test_zero_capacity();
      test_capacity_above_slots();
      test_random_traffic();
      test_backpressure();
      if (error_count == 0)
         $display("tb_lfu_cache_lookup_insert: clean");
      else
         $display("tb_lfu_cache_lookup_insert: errors");
      $finish;
   end

endmodule
